@@ design/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: explicit clock and active-low reset
`define VTK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// house clock and reset names
`define VTK_ASSERT_STD(lbl, prop, msg) \
  `VTK_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ design/vtk_pkg.sv @@
// ----------------------------------------------------------------------------
// vtk_pkg
// Shared types and constants of the terminal key escape decoder.
// ----------------------------------------------------------------------------
package vtk_pkg;

  localparam int unsigned PARAM_BUF_LEN = 16;
  localparam int unsigned PARAM_CNT_W   = 6;

  localparam int unsigned EVQ_DEPTH = 2;
  localparam int unsigned EVQ_PTR_W = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
  localparam int unsigned EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

  // received byte codes
  localparam logic [7:0] B_BS    = 8'h08;
  localparam logic [7:0] B_CR    = 8'h0d;
  localparam logic [7:0] B_ESC   = 8'h1b;
  localparam logic [7:0] B_DEL   = 8'h7f;
  localparam logic [7:0] B_LBRK  = 8'h5b;
  localparam logic [7:0] B_TILDE = 8'h7e;
  localparam logic [7:0] B_PLO   = 8'h30;
  localparam logic [7:0] B_PHI   = 8'h3f;
  localparam logic [7:0] B_ILO   = 8'h20;
  localparam logic [7:0] B_IHI   = 8'h2f;

  // special key codes
  localparam logic [7:0] K_BACK   = 8'd0;
  localparam logic [7:0] K_RETURN = 8'd1;
  localparam logic [7:0] K_DELETE = 8'd2;
  localparam logic [7:0] K_ESCAPE = 8'd3;
  localparam logic [7:0] K_UP     = 8'd4;
  localparam logic [7:0] K_DOWN   = 8'd5;
  localparam logic [7:0] K_RIGHT  = 8'd6;
  localparam logic [7:0] K_LEFT   = 8'd7;
  localparam logic [7:0] K_HOME   = 8'd8;
  localparam logic [7:0] K_END    = 8'd9;
  localparam logic [7:0] K_PGUP   = 8'd10;
  localparam logic [7:0] K_PGDN   = 8'd11;

  typedef struct packed {
    logic       is_special;
    logic [7:0] key_value;
  } key_evt_t;

endpackage

@@ design/vtk_parser.sv @@
// ----------------------------------------------------------------------------
// vtk_parser
// Front end: tracks the escape sequence state and classifies each byte.
// ----------------------------------------------------------------------------
module vtk_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        rx_byte_i,
  output logic              evt_valid_o,
  output vtk_pkg::key_evt_t evt_o
);
  import vtk_pkg::*;

  typedef enum logic [2:0] {
    ST_GROUND = 3'd0,
    ST_ESC    = 3'd1,
    ST_SKIP   = 3'd2,
    ST_PARAM  = 3'd3,
    ST_INTER  = 3'd4
  } state_e;

  state_e                 state_q, state_d;
  logic [PARAM_CNT_W-1:0] count_q, count_d;
  logic [7:0]             first_q, first_d;

  logic       is_param, is_inter;
  logic       csi_valid;
  logic [7:0] csi_key;

  assign is_param = (rx_byte_i inside {[B_PLO:B_PHI]});
  assign is_inter = (rx_byte_i inside {[B_ILO:B_IHI]});

  // decode of a csi final byte
  always_comb begin
    csi_valid = 1'b0;
    csi_key   = K_UP;
    case (rx_byte_i)
      8'h41: begin csi_valid = 1'b1; csi_key = K_UP;    end
      8'h42: begin csi_valid = 1'b1; csi_key = K_DOWN;  end
      8'h43: begin csi_valid = 1'b1; csi_key = K_RIGHT; end
      8'h44: begin csi_valid = 1'b1; csi_key = K_LEFT;  end
      B_TILDE: begin
        if (count_q == PARAM_CNT_W'(1)) begin
          case (first_q)
            8'h31: begin csi_valid = 1'b1; csi_key = K_HOME; end
            8'h34: begin csi_valid = 1'b1; csi_key = K_END;  end
            8'h35: begin csi_valid = 1'b1; csi_key = K_PGUP; end
            8'h36: begin csi_valid = 1'b1; csi_key = K_PGDN; end
            default: csi_valid = 1'b0;
          endcase
        end
      end
      default: csi_valid = 1'b0;
    endcase
  end

  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    first_d         = first_q;
    evt_valid_o     = 1'b0;
    evt_o.is_special = 1'b1;
    evt_o.key_value  = rx_byte_i;
    case (state_q)
      ST_GROUND: begin
        evt_valid_o = 1'b1;
        case (rx_byte_i)
          B_BS:  evt_o.key_value = K_BACK;
          B_CR:  evt_o.key_value = K_RETURN;
          B_DEL: evt_o.key_value = K_DELETE;
          B_ESC: begin
            evt_valid_o = 1'b0;
            state_d     = ST_ESC;
          end
          default: evt_o.is_special = 1'b0;
        endcase
      end
      ST_ESC: begin
        if (rx_byte_i == B_ESC) begin
          evt_valid_o     = 1'b1;
          evt_o.key_value = K_ESCAPE;
          state_d         = ST_GROUND;
        end else if (rx_byte_i == B_LBRK) begin
          count_d = '0;
          state_d = ST_PARAM;
        end else if (rx_byte_i inside {8'h4e, 8'h4f, 8'h50, 8'h5c, 8'h5d, 8'h58,
                                       8'h5e, 8'h5f}) begin
          // these introducers swallow exactly one byte
          state_d = ST_SKIP;
        end else begin
          state_d = ST_GROUND;
        end
      end
      ST_PARAM: begin
        if (is_param) begin
          if (count_q < PARAM_CNT_W'(PARAM_BUF_LEN - 1)) begin
            if (count_q == '0) first_d = rx_byte_i;
            count_d = count_q + PARAM_CNT_W'(1);
          end
        end else if (is_inter) begin
          state_d = ST_INTER;
        end else begin
          evt_valid_o     = csi_valid;
          evt_o.key_value = csi_key;
          state_d         = ST_GROUND;
        end
      end
      ST_INTER: begin
        if (!is_inter) begin
          evt_valid_o     = csi_valid;
          evt_o.key_value = csi_key;
          state_d         = ST_GROUND;
        end
      end
      default: state_d = ST_GROUND;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_GROUND;
      count_q <= '0;
      first_q <= '0;
    end else if (fire_i) begin
      state_q <= state_d;
      count_q <= count_d;
      first_q <= first_d;
    end
  end

endmodule

@@ design/vtk_evq.sv @@
// ----------------------------------------------------------------------------
// vtk_evq
// Back end: short event queue that holds key events until taken.
// ----------------------------------------------------------------------------
module vtk_evq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vtk_pkg::key_evt_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output vtk_pkg::key_evt_t data_o
);
  import vtk_pkg::*;

  key_evt_t               mem_q [EVQ_DEPTH];
  logic [EVQ_PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [EVQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == EVQ_CNT_W'(EVQ_DEPTH));
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == EVQ_PTR_W'(EVQ_DEPTH - 1)) ? '0 : wptr_q + EVQ_PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == EVQ_PTR_W'(EVQ_DEPTH - 1)) ? '0 : rptr_q + EVQ_PTR_W'(1);
    end
    if (push_i && !do_pop) cnt_d = cnt_q + EVQ_CNT_W'(1);
    else if (!push_i && do_pop) cnt_d = cnt_q - EVQ_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

@@ design/vt100_key_escape_decoder.sv @@
// ----------------------------------------------------------------------------
// vt100_key_escape_decoder
// Turns received terminal bytes into key events.
// ----------------------------------------------------------------------------
// Input channel: one terminal byte per request on rx_byte_i (valid/ready).
// Output channel: at most one key event per byte, is_special_o plus
// key_value_o (valid/ready). Bytes that only move the sequence state
// (escape, csi parameters, skipped bytes) give no event.
// Output: an event is written into the event queue when its byte is taken
// and is presented from the queue head. Throughput: one byte per cycle
// while in_ready_o is high; the event queue lets a pop and a push share a cycle.
// The parser and the two-entry event queue are decoupled: while the
// receiver stalls the queue fills, and once it is full in_ready_o drops
// unless an event leaves in the same cycle.
// Reset: parser returns to the ground state with an empty parameter
// count, and the queue empties; no events are pending after reset.
// ----------------------------------------------------------------------------
module vt100_key_escape_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_special_o,
  output logic [7:0] key_value_o
);
  import vtk_pkg::*;

  logic     fire, evt_valid, q_full;
  key_evt_t evt, q_data;

  assign in_ready_o = !q_full || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  vtk_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .rx_byte_i   (rx_byte_i),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  vtk_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire && evt_valid),
    .data_i  (evt),
    .full_o  (q_full),
    .valid_o (out_valid_o),
    .pop_i   (out_ready_i),
    .data_o  (q_data)
  );

  assign is_special_o = q_data.is_special;
  assign key_value_o  = q_data.key_value;

endmodule

@@ design/vtk_checker.sv @@
// ----------------------------------------------------------------------------
// vtk_checker
// Port-level checks of the key escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtk_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       is_special_o,
  input logic [7:0] key_value_o
);
  import vtk_pkg::*;

  logic out_stall;
  assign out_stall = out_valid_o && !out_ready_i;

  property p_out_stable;
    out_stall |=> ($stable(key_value_o) && $stable(is_special_o));
  endproperty

  property p_special_range;
    (out_valid_o && is_special_o) |-> (key_value_o <= K_PGDN);
  endproperty

  property p_no_spurious;
    (!out_valid_o && !(in_valid_i && in_ready_o)) |=> !out_valid_o;
  endproperty

  `VTK_ASSERT_STD(a_out_hold, out_stall |=> out_valid_o, "output request dropped while stalled")
  `VTK_ASSERT_STD(a_out_stable, p_out_stable, "output payload changed while stalled")
  `VTK_ASSERT(a_special_range, clk_i, rst_ni, p_special_range, "special key out of range")
  `VTK_ASSERT_STD(a_no_spurious, p_no_spurious, "event without an accepted byte")
  `VTK_ASSERT_STD(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input stalled when empty")

endmodule

bind vt100_key_escape_decoder vtk_checker u_vtk_checker (.*);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the terminal key escape decoder: directed escape,
// csi and control byte cases, then a long stream of random well-formed and
// broken sequences, with random stalls on both channels; each key event is
// compared with an in-bench model of the parser.
// ----------------------------------------------------------------------------
module tb;
  import vtk_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1300;

  // csi final bytes
  localparam logic [7:0] B_FIN_UP    = 8'h41;
  localparam logic [7:0] B_FIN_DOWN  = 8'h42;
  localparam logic [7:0] B_FIN_RIGHT = 8'h43;
  localparam logic [7:0] B_FIN_LEFT  = 8'h44;
  // csi parameter digits for the tilde keys
  localparam logic [7:0] B_P_HOME = 8'h31;
  localparam logic [7:0] B_P_END  = 8'h34;
  localparam logic [7:0] B_P_PGUP = 8'h35;
  localparam logic [7:0] B_P_PGDN = 8'h36;
  // escape introducers that swallow one byte
  localparam logic [7:0] B_SS2 = 8'h4e;
  localparam logic [7:0] B_SS3 = 8'h4f;
  localparam logic [7:0] B_DCS = 8'h50;
  localparam logic [7:0] B_ST  = 8'h5c;
  localparam logic [7:0] B_OSC = 8'h5d;
  localparam logic [7:0] B_SOS = 8'h58;
  localparam logic [7:0] B_PM  = 8'h5e;
  localparam logic [7:0] B_APC = 8'h5f;

  typedef enum logic [3:0] {
    PS_GROUND = 4'd0,
    PS_ESC    = 4'd1,
    PS_SKIP   = 4'd2,
    PS_PARAM  = 4'd3,
    PS_INTER  = 4'd4
  } parse_st_e;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i    = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic       is_special_o;
  logic [7:0] key_value_o;

  vt100_key_escape_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_special_o(is_special_o),
    .key_value_o (key_value_o)
  );

  // parser model state
  parse_st_e  parse_st    = PS_GROUND;
  logic [5:0] kept_params = '0;
  logic [7:0] lead_param  = '0;

  key_evt_t expected_keys[$];
  int       errors     = 0;
  int       bytes_sent = 0;
  bit       no_idle    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void report_fault(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic void push_key(input logic special, input logic [7:0] value);
    key_evt_t k;
    k.is_special = special;
    k.key_value  = value;
    expected_keys.push_back(k);
  endfunction

  function automatic bit is_skip_intro(input logic [7:0] b);
    case (b)
      B_SS2, B_SS3, B_DCS, B_ST, B_OSC, B_SOS, B_PM, B_APC: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void finish_csi(input logic [7:0] b);
    parse_st = PS_GROUND;
    case (b)
      B_FIN_UP:    push_key(1'b1, K_UP);
      B_FIN_DOWN:  push_key(1'b1, K_DOWN);
      B_FIN_RIGHT: push_key(1'b1, K_RIGHT);
      B_FIN_LEFT:  push_key(1'b1, K_LEFT);
      B_TILDE: begin
        if (kept_params == 6'd1) begin
          case (lead_param)
            B_P_HOME: push_key(1'b1, K_HOME);
            B_P_END:  push_key(1'b1, K_END);
            B_P_PGUP: push_key(1'b1, K_PGUP);
            B_P_PGDN: push_key(1'b1, K_PGDN);
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_key_event(input logic [7:0] b);
    case (parse_st)
      PS_GROUND: begin
        case (b)
          B_BS:    push_key(1'b1, K_BACK);
          B_CR:    push_key(1'b1, K_RETURN);
          B_DEL:   push_key(1'b1, K_DELETE);
          B_ESC:   parse_st = PS_ESC;
          default: push_key(1'b0, b);
        endcase
      end
      PS_ESC: begin
        if (b == B_ESC) begin
          push_key(1'b1, K_ESCAPE);
          parse_st = PS_GROUND;
        end else if (b == B_LBRK) begin
          kept_params = '0;
          parse_st = PS_PARAM;
        end else if (is_skip_intro(b)) begin
          parse_st = PS_SKIP;
        end else begin
          parse_st = PS_GROUND;
        end
      end
      PS_PARAM: begin
        if (b >= B_PLO && b <= B_PHI) begin
          // count saturates, the first byte stays
          if (kept_params < PARAM_BUF_LEN - 1) begin
            if (kept_params == 6'd0) lead_param = b;
            kept_params = kept_params + 6'd1;
          end
        end else if (b >= B_ILO && b <= B_IHI) begin
          parse_st = PS_INTER;
        end else begin
          finish_csi(b);
        end
      end
      PS_INTER: begin
        if (!(b >= B_ILO && b <= B_IHI)) finish_csi(b);
      end
      default: parse_st = PS_GROUND;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 12) gap = 1;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_key_event(b);
    bytes_sent++;
  endtask

  // hold off requests until every predicted event is out
  task automatic wait_for_keys();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_keys.size() != 0);
  endtask

  task automatic test_ground_bytes();
    send_byte(B_BS);
    send_byte(B_CR);
    send_byte(B_DEL);
    send_byte(8'h00);
    send_byte(8'hff);
  endtask

  task automatic test_escape_prefix();
    send_byte(B_ESC);
    send_byte(B_ESC);
    // unknown byte after escape is dropped
    send_byte(B_ESC);
    send_byte(8'h7a);
    // escape swallowed by a single-shift
    send_byte(B_ESC);
    send_byte(B_SS3);
    send_byte(B_ESC);
  endtask

  task automatic test_csi_keys();
    send_byte(B_ESC);
    send_byte(B_LBRK);
    send_byte(B_FIN_UP);
    send_byte(B_ESC);
    send_byte(B_LBRK);
    send_byte(B_P_PGUP);
    send_byte(B_TILDE);
    // intermediate byte does not clear the kept parameter
    send_byte(B_ESC);
    send_byte(B_LBRK);
    send_byte(B_P_HOME);
    send_byte(B_IHI);
    send_byte(B_TILDE);
  endtask

  task automatic send_random_csi();
    int n_par;
    int n_int;
    int r;
    logic [7:0] fin;
    send_byte(B_ESC);
    send_byte(B_LBRK);
    r = $urandom_range(99);
    if (r < 40)      n_par = 1;
    else if (r < 60) n_par = 0;
    else if (r < 85) n_par = $urandom_range(2, 4);
    else if (r < 95) n_par = $urandom_range(12, 20);
    else             n_par = $urandom_range(60, 70);
    for (int i = 0; i < n_par; i++) begin
      if (n_par == 1 && $urandom_range(99) < 70) begin
        case ($urandom_range(3))
          0: send_byte(B_P_HOME);
          1: send_byte(B_P_END);
          2: send_byte(B_P_PGUP);
          default: send_byte(B_P_PGDN);
        endcase
      end else begin
        send_byte(8'($urandom_range(B_PLO, B_PHI)));
      end
    end
    n_int = ($urandom_range(99) < 80) ? 0 : $urandom_range(1, 2);
    for (int i = 0; i < n_int; i++) send_byte(8'($urandom_range(B_ILO, B_IHI)));
    r = $urandom_range(99);
    if (r < 40) begin
      case ($urandom_range(3))
        0: fin = B_FIN_UP;
        1: fin = B_FIN_DOWN;
        2: fin = B_FIN_RIGHT;
        default: fin = B_FIN_LEFT;
      endcase
    end else if (r < 75) begin
      fin = B_TILDE;
    end else if (r < 85) begin
      fin = 8'($urandom_range(B_PLO, B_PHI));
    end else begin
      fin = 8'($urandom_range(0, 255));
    end
    send_byte(fin);
  endtask

  task automatic test_random_stream();
    int  r;
    bit  paused;
    int  start;
    logic [7:0] intro;
    paused = 1'b0;
    start  = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      no_idle = (bytes_sent - start >= 450) && (bytes_sent - start < 750);
      if (!paused && bytes_sent - start >= 1000) begin
        wait_for_keys();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 30) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (r < 65) begin
        send_random_csi();
      end else if (r < 75) begin
        send_byte(B_ESC);
        send_byte(B_ESC);
      end else if (r < 85) begin
        case ($urandom_range(7))
          0: intro = B_SS2;
          1: intro = B_SS3;
          2: intro = B_DCS;
          3: intro = B_ST;
          4: intro = B_OSC;
          5: intro = B_SOS;
          6: intro = B_PM;
          default: intro = B_APC;
        endcase
        send_byte(B_ESC);
        send_byte(intro);
        send_byte(8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        send_byte(B_ESC);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(2))
          0: send_byte(B_BS);
          1: send_byte(B_CR);
          default: send_byte(B_DEL);
        endcase
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin : check_keys
    key_evt_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_keys.size() == 0) begin
        report_fault($sformatf("unexpected key event: is_special=%0b key_value=%0d",
                               is_special_o, key_value_o));
      end else begin
        want = expected_keys.pop_front();
        if (is_special_o !== want.is_special)
          report_fault($sformatf("is_special mismatch: expected %0b, got %0b",
                                 want.is_special, is_special_o));
        if (key_value_o !== want.key_value)
          report_fault($sformatf("key_value mismatch: expected %0d, got %0d",
                                 want.key_value, key_value_o));
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stalled = 0;
      else stalled++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ground_bytes();
    test_escape_prefix();
    test_csi_keys();
    wait_for_keys();
    test_random_stream();
    wait_for_keys();
    repeat (10) @(posedge clk_i);
    if (expected_keys.size() != 0)
      report_fault($sformatf("%0d key events never arrived", expected_keys.size()));
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/vtk_pkg.sv
design/vtk_parser.sv
design/vtk_evq.sv
design/vt100_key_escape_decoder.sv
design/vtk_checker.sv
test/tb.sv
